>>> hw/rtl/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter unit.
// Depends on nothing; every other file of the block imports it.
package skf_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned EST_W     = 32;
  localparam int unsigned COV_W     = 32;
  localparam int unsigned GAIN_W    = 25;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  // Gain divider: one quotient bit a cycle, quotient is FRAC_W + 1 bits wide
  localparam int unsigned DIV_STEPS = GAIN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = COV_W + 2;
  localparam int unsigned MUL_B_W = GAIN_W + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [COV_W-1:0]  RESET_COVARIANCE        = 32'd335544;
  localparam logic [COV_W-1:0]  RESET_PROCESS_NOISE     = 32'd16777;
  localparam logic [COV_W-1:0]  RESET_MEASUREMENT_NOISE = 32'd9110028;
  localparam logic [GAIN_W-1:0] GAIN_ONE                = 25'h100_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DINIT,
    ST_DIV,
    ST_GAIN,
    ST_MULE,
    ST_UPDE,
    ST_MULC,
    ST_UPDC,
    ST_DONE
  } skf_state_t;

  typedef struct packed {
    logic capture;
    logic div_init;
    logic div_step;
    logic gain_ld;
    logic mul_en;
    logic mul_cov;
    logic upd_est;
    logic upd_cov;
    logic out_ld;
  } skf_cmd_t;

  typedef struct packed {
    logic div_last;
  } skf_status_t;

endpackage

>>> hw/rtl/skf_in_if.sv
// Input channel of the scalar Kalman filter: one sensor sample per item.
// Depends on skf_pkg.
interface skf_in_if
  import skf_pkg::*;
  (input logic clk);

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (input clk, output valid, input ready, output sample);
  modport sink   (input clk, input valid, output ready, input sample);

endinterface

>>> hw/rtl/skf_out_if.sv
// Result channel of the scalar Kalman filter: estimate and gain per item.
// Depends on skf_pkg.
interface skf_out_if
  import skf_pkg::*;
  (input logic clk);

  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;
  logic [GAIN_W-1:0]       gain;

  modport source (input clk, output valid, input ready, output estimate, output gain);
  modport sink   (input clk, input valid, output ready, input estimate, input gain);

endinterface

>>> hw/rtl/skf_cfg_if.sv
// Configuration write channel of the scalar Kalman filter.
// Depends on skf_pkg.
interface skf_cfg_if
  import skf_pkg::*;
  (input logic clk);

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (input clk, output valid, input ready, output index, output data);
  modport sink   (input clk, input valid, output ready, input index, input data);

endinterface

>>> hw/rtl/skf_ctrl.sv
// Controller of the scalar Kalman filter: sequences the datapath per item
// and owns the handshake flags. Depends on skf_pkg.
module skf_ctrl
  import skf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  skf_status_t status,
  output skf_cmd_t    cmd
);

  skf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.gain_ld = 1'b1;
        state_nxt   = ST_MULE;
      end
      ST_MULE: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_UPDE;
      end
      ST_UPDE: begin
        cmd.upd_est = 1'b1;
        state_nxt   = ST_MULC;
      end
      ST_MULC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_cov = 1'b1;
        state_nxt   = ST_UPDC;
      end
      ST_UPDC: begin
        cmd.upd_cov = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/skf_dp.sv
// Datapath of the scalar Kalman filter: configuration and filter state,
// restoring gain divider, shared multiplier and output register. Depends on skf_pkg.
module skf_dp
  import skf_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  skf_cmd_t                   cmd,
  output skf_status_t                status,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DAT_W-1:0]       cfg_data,
  output logic signed [EST_W-1:0]    out_estimate,
  output logic [GAIN_W-1:0]          out_gain
);

  logic [COV_W-1:0]         pn_r, mn_r, cov_r;
  logic signed [EST_W-1:0]  est_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [COV_W-1:0]         pred_r;
  logic [COV_W:0]           den_r;
  logic [COV_W+1:0]         rem_r;
  logic [GAIN_W-1:0]        quo_r, gain_r;
  logic [DIV_CNT_W-1:0]     cnt_r;
  logic signed [EST_W:0]    diff_r;
  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [EST_W-1:0]  out_est_r;
  logic [GAIN_W-1:0]        out_gain_r;

  logic [COV_W:0]            pred_sum;
  logic [COV_W-1:0]          pred_sat;
  logic                      div_ge;
  logic [COV_W+1:0]          div_sub;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] rnd;
  logic signed [MUL_P_W-FRAC_W-1:0] delta;
  logic signed [MUL_P_W-FRAC_W:0]   est_sum;
  logic signed [EST_W-1:0]   est_sat;

  // Predicted covariance, saturating at all ones
  assign pred_sum = {1'b0, cov_r} + {1'b0, pn_r};
  assign pred_sat = pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];

  // Restoring division step; remainder stays below the divisor before the shift
  assign div_ge  = (rem_r >= {1'b0, den_r});
  assign div_sub = div_ge ? (rem_r - {1'b0, den_r}) : rem_r;

  // Shared multiplier operands: estimate correction or covariance scaling
  always_comb begin
    if (cmd.mul_cov) begin
      mul_a = signed'({2'b00, pred_r});
      mul_b = signed'({1'b0, GAIN_ONE - gain_r});
    end else begin
      mul_a = MUL_A_W'(diff_r);
      mul_b = signed'({1'b0, gain_r});
    end
  end

  // Round to nearest, ties up, then saturate the new estimate
  assign rnd     = prod_r + MUL_P_W'(1 << (FRAC_W - 1));
  assign delta   = rnd[MUL_P_W-1:FRAC_W];
  assign est_sum = (MUL_P_W-FRAC_W+1)'(est_r) + (MUL_P_W-FRAC_W+1)'(delta);

  always_comb begin
    if (est_sum[MUL_P_W-FRAC_W:EST_W-1] == '0 || est_sum[MUL_P_W-FRAC_W:EST_W-1] == '1) begin
      est_sat = est_sum[EST_W-1:0];
    end else if (est_sum[MUL_P_W-FRAC_W]) begin
      est_sat = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      est_sat = {1'b0, {(EST_W-1){1'b1}}};
    end
  end

  assign status.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // Configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r  <= RESET_PROCESS_NOISE;
      mn_r  <= RESET_MEASUREMENT_NOISE;
      est_r <= '0;
      cov_r <= RESET_COVARIANCE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROCESS_NOISE:     pn_r <= cfg_data;
          CFG_MEASUREMENT_NOISE: mn_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.upd_est) begin
        est_r <= est_sat;
      end
      if (cmd.upd_cov) begin
        cov_r <= prod_r[FRAC_W+COV_W-1:FRAC_W];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_sample;
      pred_r   <= pred_sat;
    end
    if (cmd.div_init) begin
      den_r <= {1'b0, pred_r} + {1'b0, mn_r};
      rem_r <= {2'b00, pred_r};
      quo_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= {div_sub[COV_W:0], 1'b0};
      quo_r <= {quo_r[GAIN_W-2:0], div_ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.gain_ld) begin
      // zero denominator: gain stays zero
      gain_r <= (den_r == '0) ? '0 : quo_r;
      diff_r <= (EST_W+1)'(signed'({sample_r, 16'h0000})) - (EST_W+1)'(est_r);
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.out_ld) begin
      out_est_r  <= est_r;
      out_gain_r <= gain_r;
    end
  end

  assign out_estimate = out_est_r;
  assign out_gain     = out_gain_r;

endmodule

>>> hw/rtl/scalar_kalman_filter_unit.sv
// Top level of the scalar Kalman filter unit: controller plus datapath.
// Depends on skf_pkg, skf_in_if, skf_out_if, skf_cfg_if, skf_ctrl and skf_dp.
//
// One-dimensional Kalman filter in fixed point. Each item carries a signed
// 16-bit sample; the unit returns one item holding the new estimate (signed
// Q16.16) and the gain used (unsigned, 24 fraction bits, at most 1.0). The
// covariance is predicted by a saturating add of the process noise, the gain
// is the predicted covariance over (predicted covariance + measurement
// noise), the estimate moves toward the sample by the gain (rounded to
// nearest, ties up) and the covariance is scaled by (1 - gain). After an
// item is accepted, the divider is set up, the restoring divider yields one
// gain bit a cycle, the gain is loaded, two passes through the single shared
// multiplier each precede their update step, and the output is loaded. A new
// item is taken once the previous one has reached the output register; a
// waiting result is held in the output register and the next item is
// accepted meanwhile. The configuration port is always ready; write it only
// while the unit is idle. Writes to unknown indexes are dropped.
module scalar_kalman_filter_unit
  import skf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  skf_in_if.sink    in_ch,
  skf_out_if.source out_ch,
  skf_cfg_if.sink   cfg_ch
);

  skf_cmd_t    cmd;
  skf_status_t status;

  // Configuration writes are taken at once
  assign cfg_ch.ready = 1'b1;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  skf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_sample    (in_ch.sample),
    .cfg_we       (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_estimate (out_ch.estimate),
    .out_gain     (out_ch.gain)
  );

endmodule
